// ===== rtl/core/elrb_pkg.sv =====
// Shared types, constants and codes for the event log ring buffer.
// Depends on nothing; used by the controller, datapath and top level.
package elrb_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
    localparam logic [63:0] TIME_NONE     = 64'h8000000000000000;
    localparam logic [63:0] TIME_MAX_REL  = 64'h0C00000000000000;
    localparam logic [31:0] NO_ENTRY      = 32'hFFFFFFFE;
    localparam logic [31:0] ID_OLDEST     = 32'h00000000;
    localparam logic [31:0] ID_NEWEST     = 32'hFFFFFFFF;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_STAMP  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;
    localparam logic [1:0] REG_CAP    = 2'd3;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_PREPEND = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_GET     = 3'd3;
    localparam logic [2:0] OP_OVF_RST = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_ABSENT   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic finish;
    } t_cmd;

endpackage

// ===== rtl/core/elrb_ctrl.sv =====
// Controller state machine for the event log ring buffer.
// Depends on elrb_pkg.
module elrb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output elrb_pkg::t_cmd o_cmd
);

    elrb_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= elrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            elrb_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = elrb_pkg::S_EXEC;
                end
            end
            elrb_pkg::S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = elrb_pkg::S_DONE;
            end
            elrb_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = elrb_pkg::S_IDLE;
            end
            default: n_state = elrb_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/elrb_dp.sv =====
// Datapath of the event log ring buffer: entry memories, ring pointers,
// configuration registers and result registers. Depends on elrb_pkg.
module elrb_dp #(
    parameter int DEPTH        = elrb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = elrb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  elrb_pkg::t_cmd          i_cmd,
    input  logic                    i_cfg_write,
    input  logic [1:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    input  logic [2:0]              i_operation,
    input  logic [PAYLOAD_BITS-1:0] i_event_payload,
    input  logic                    i_event_is_user,
    input  logic signed [63:0]      i_event_time,
    input  logic [31:0]             i_wall_seconds,
    input  logic [31:0]             i_entry_id,
    output logic                    o_result_valid,
    output logic [1:0]              o_status,
    output logic [31:0]             o_found_id,
    output logic [PAYLOAD_BITS-1:0] o_entry_payload,
    output logic signed [63:0]      o_entry_time,
    output logic [31:0]             o_prev_id,
    output logic [31:0]             o_following_id,
    output logic [6:0]              o_entry_count,
    output logic                    o_overflow_flag,
    output logic signed [63:0]      o_last_update,
    output logic signed [63:0]      o_current_time
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);

    // Entry memories.
    logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];
    logic [63:0]             stamp_mem   [DEPTH];

    // Configuration.
    logic        r_enabled, r_stamp_clk;
    logic [63:0] r_offset;
    logic [6:0]  r_capacity;

    // Ring state.
    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_next_id, n_next_id;
    logic          r_ovf, n_ovf;
    logic [63:0]   r_last, n_last;

    // Captured item.
    logic [2:0]              r_op;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    r_user;
    logic [63:0]             r_own_time;
    logic [31:0]             r_want;
    logic [63:0]             r_clock_prod, r_clock_now;

    // Per-item decisions held between execute and finish.
    logic [1:0]              r_status, n_status;
    logic [31:0]             r_found, n_found;
    logic [31:0]             r_prev, n_prev, r_next, n_next;
    logic                    r_is_get, n_is_get;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;
    logic [63:0]             r_rd_stamp;
    logic [63:0]             r_wr_stamp;

    // Folds a sum of two ring positions back into the ring.
    function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] v);
        return (v >= DEPTH_A) ? AW'(v - DEPTH_A) : v[AW-1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_stamp_clk <= 1'b1;
            r_offset    <= '0;
            r_capacity  <= 7'd64;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                elrb_pkg::REG_ENABLE: r_enabled   <= i_cfg_data[0];
                elrb_pkg::REG_STAMP:  r_stamp_clk <= i_cfg_data[0];
                elrb_pkg::REG_OFFSET: begin
                    if (i_cfg_data != elrb_pkg::TIME_NONE) begin
                        if (!i_cfg_data[63] && i_cfg_data > elrb_pkg::TIME_MAX_REL) begin
                            r_offset <= '0;
                        end else begin
                            r_offset <= i_cfg_data;
                        end
                    end
                end
                elrb_pkg::REG_CAP:    r_capacity  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Capture the item and start the clock product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_operation;
            r_payload    <= i_event_payload;
            r_user       <= i_event_is_user;
            r_own_time   <= i_event_time;
            r_want       <= i_entry_id;
            r_clock_prod <= 64'(i_wall_seconds) * elrb_pkg::NS_PER_SECOND;
        end
        if (i_cmd.execute) begin
            r_clock_now <= r_clock_prod + r_offset;
        end
    end

    // Effective capacity and derived positions.
    logic [CW-1:0] cap;
    logic [31:0]   first_id, pos;
    logic [AW-1:0] rd_slot, app_slot, pre_slot, app_base;
    logic [CW-1:0] app_offs;
    logic [63:0]   clock_now, new_stamp;
    logic          full, wr_en;
    logic [AW-1:0] wr_slot;

    always_comb begin
        if (r_capacity == 7'd0 || 32'(r_capacity) > DEPTH) begin
            cap = DEPTH_C;
        end else begin
            cap = CW'(r_capacity);
        end
        full      = r_count >= cap;
        clock_now = r_clock_prod + r_offset;
        new_stamp = r_stamp_clk ? clock_now : r_own_time;
        first_id  = r_next_id - 32'(r_count);
        if (r_want == elrb_pkg::ID_NEWEST) begin
            pos = 32'(r_count) - 32'd1;
        end else if (r_want == elrb_pkg::ID_OLDEST) begin
            pos = '0;
        end else begin
            pos = r_want - first_id;
        end
        // A held position is below the depth, so its low bits are enough.
        rd_slot  = wrap_slot({1'b0, r_oldest} + {1'b0, pos[AW-1:0]});
        app_base = full ? wrap_slot({1'b0, r_oldest} + (AW+1)'(1)) : r_oldest;
        app_offs = r_count - (full ? CW'(1) : CW'(0));
        app_slot = wrap_slot({1'b0, app_base} + {1'b0, app_offs[AW-1:0]});
        pre_slot = (r_oldest == '0) ? AW'(DEPTH - 1) : r_oldest - AW'(1);
    end

    // Execute step: decide the operation and update ring state.
    always_comb begin
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_ovf     = r_ovf;
        n_last    = r_last;
        n_status  = elrb_pkg::ST_OK;
        n_found   = '0;
        n_prev    = elrb_pkg::NO_ENTRY;
        n_next    = elrb_pkg::NO_ENTRY;
        n_is_get  = 1'b0;
        wr_en     = 1'b0;
        wr_slot   = app_slot;
        unique case (r_op)
            elrb_pkg::OP_APPEND: begin
                if (!r_enabled && !r_user) begin
                    n_status = elrb_pkg::ST_DISABLED;
                end else begin
                    if (full) begin
                        n_oldest = app_base;
                        n_ovf    = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_last    = new_stamp;
                    wr_en     = 1'b1;
                    n_found   = r_next_id;
                    n_next_id = r_next_id + 32'd1;
                end
            end
            elrb_pkg::OP_PREPEND: begin
                if (!r_enabled) begin
                    n_status = elrb_pkg::ST_DISABLED;
                end else if (full) begin
                    n_status = elrb_pkg::ST_NO_SPACE;
                end else begin
                    n_found   = first_id;
                    n_oldest  = pre_slot;
                    wr_slot   = pre_slot;
                    wr_en     = 1'b1;
                    n_last    = new_stamp;
                    n_count   = r_count + CW'(1);
                    n_next_id = r_next_id + 32'd1;
                end
            end
            elrb_pkg::OP_CLEAR: begin
                n_oldest  = '0;
                n_count   = '0;
                n_next_id = 32'd1;
                n_ovf     = 1'b0;
                n_last    = elrb_pkg::TIME_NONE;
            end
            elrb_pkg::OP_GET: begin
                if (r_count == '0 || pos >= 32'(r_count)) begin
                    n_status = elrb_pkg::ST_ABSENT;
                end else begin
                    n_is_get = 1'b1;
                    n_found  = first_id + pos;
                    n_prev   = (pos == 32'd0) ? elrb_pkg::NO_ENTRY : n_found - 32'd1;
                    n_next   = (pos == 32'(r_count) - 32'd1)
                               ? elrb_pkg::NO_ENTRY : n_found + 32'd1;
                end
            end
            elrb_pkg::OP_OVF_RST: n_ovf = 1'b0;
            default: ;
        endcase
    end

    // Ring state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_next_id <= 32'd1;
            r_ovf     <= 1'b0;
            r_last    <= elrb_pkg::TIME_NONE;
        end else if (i_cmd.execute) begin
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_ovf     <= n_ovf;
            r_last    <= n_last;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (wr_en) begin
                payload_mem[wr_slot] <= r_payload;
                stamp_mem[wr_slot]   <= new_stamp;
            end
            r_rd_payload <= payload_mem[rd_slot];
            r_rd_stamp   <= stamp_mem[rd_slot];
            r_status     <= n_status;
            r_found      <= n_found;
            r_prev       <= n_prev;
            r_next       <= n_next;
            r_is_get     <= n_is_get;
            r_wr_stamp   <= new_stamp;
        end
    end

    // Result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status       <= r_status;
            o_found_id     <= r_found;
            o_prev_id      <= r_prev;
            o_following_id <= r_next;
            o_entry_count  <= 7'(r_count);
            o_overflow_flag <= r_ovf;
            o_last_update  <= r_last;
            o_current_time <= r_clock_now;
            if (r_is_get) begin
                o_entry_payload <= r_rd_payload;
                o_entry_time    <= r_rd_stamp;
            end else if (r_status == elrb_pkg::ST_OK
                         && (r_op == elrb_pkg::OP_APPEND || r_op == elrb_pkg::OP_PREPEND)) begin
                o_entry_payload <= r_payload;
                o_entry_time    <= r_wr_stamp;
            end else begin
                o_entry_payload <= '0;
                o_entry_time    <= '0;
            end
        end
    end

endmodule

// ===== rtl/core/event_log_ring_buffer.sv =====
// Top level of the event log ring buffer: controller plus datapath.
// Depends on elrb_pkg, elrb_ctrl and elrb_dp.
//
// Usage: raise i_start with the operation fields while o_busy is low; the
// item is taken at that edge. Exactly one result beat follows, shown for one
// cycle with o_result_valid high: the accepting edge registers the item and
// the wall clock product, the execute state does the memory read and
// write-back with the ring pointer update, and the done state registers the
// result. o_busy stays high in the execute and done states, so a new item is
// taken only once the last one is through. The receiver cannot stall: the
// result is lost if not taken. Configuration is written through
// i_cfg_valid/o_cfg_ready with a register index and data; o_cfg_ready is
// always high and writes must only be made while the block is idle. Reset
// (i_rst_n low, synchronous) empties the log, sets the next id to one,
// clears the overflow flag, marks the last update as unspecified and
// restores the register defaults. Entry memories are not cleared; only held
// entries are ever shown at the outputs.
module event_log_ring_buffer #(
    parameter int DEPTH        = elrb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = elrb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [2:0]              i_operation,
    input  logic [PAYLOAD_BITS-1:0] i_event_payload,
    input  logic                    i_event_is_user,
    input  logic signed [63:0]      i_event_time,
    input  logic [31:0]             i_wall_seconds,
    input  logic [31:0]             i_entry_id,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    output logic                    o_result_valid,
    output logic [1:0]              o_status,
    output logic [31:0]             o_found_id,
    output logic [PAYLOAD_BITS-1:0] o_entry_payload,
    output logic signed [63:0]      o_entry_time,
    output logic [31:0]             o_prev_id,
    output logic [31:0]             o_following_id,
    output logic [6:0]              o_entry_count,
    output logic                    o_overflow_flag,
    output logic signed [63:0]      o_last_update,
    output logic signed [63:0]      o_current_time
);

    elrb_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    elrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    elrb_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_event_payload (i_event_payload),
        .i_event_is_user (i_event_is_user),
        .i_event_time    (i_event_time),
        .i_wall_seconds  (i_wall_seconds),
        .i_entry_id      (i_entry_id),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_found_id      (o_found_id),
        .o_entry_payload (o_entry_payload),
        .o_entry_time    (o_entry_time),
        .o_prev_id       (o_prev_id),
        .o_following_id  (o_following_id),
        .o_entry_count   (o_entry_count),
        .o_overflow_flag (o_overflow_flag),
        .o_last_update   (o_last_update),
        .o_current_time  (o_current_time)
    );

endmodule
